// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by aes_encrypt_round
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AER_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes round assertion failed");

// next-cycle implication, held off during reset
`define AER_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes round assertion failed");

`endif

// ===== hw/rtl/aer_pkg.sv =====
package aer_pkg;

    // one state column, row 0 in the top byte
    typedef logic [31:0] t_column;

    // full 128-bit state, byte 0 in the top byte
    typedef logic [127:0] t_block;

    localparam int NumBytes = 16;
    localparam int NumCols  = 4;

    // forward s-box
    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

endpackage

// ===== hw/rtl/aer_mix_column.sv =====
module aer_mix_column
    import aer_pkg::*;
(
    input  t_column i_col,
    output t_column o_col
);

    // reduction polynomial low byte
    localparam logic [7:0] Reduce = 8'h1b;

    // multiply by two in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? Reduce : 8'h00);
    endfunction

    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;

    // split column and double each byte
    assign a0 = i_col[31:24];
    assign a1 = i_col[23:16];
    assign a2 = i_col[15:8];
    assign a3 = i_col[7:0];
    assign d0 = xtime(a0);
    assign d1 = xtime(a1);
    assign d2 = xtime(a2);
    assign d3 = xtime(a3);

    // circulant 2 3 1 1 matrix
    assign o_col[31:24] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
    assign o_col[23:16] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
    assign o_col[15:8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
    assign o_col[7:0]   = d0 ^ a0 ^ a1 ^ a2 ^ d3;

endmodule

// ===== hw/rtl/aes_encrypt_round.sv =====
// pipeline from input transfer to result valid: s-box, mix and key add stages, in that order
// throughput: one block per cycle while the output is not stalled; each of the three stages holds one block
// a stall at the output backs up stage by stage, input ready drops only when all are full
// reset: synchronous active-low i_rst_n clears the stage valid bits only
`include "assert_macros.svh"
module aes_encrypt_round
    import aer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_state_high,
    input  logic [63:0] i_state_low,
    input  logic [63:0] i_key_high,
    input  logic [63:0] i_key_low,
    input  logic        i_final_round,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);

    t_block w_state_in;
    t_block n_sub;
    t_block n_mix;
    t_block w_mixed;

    // stage registers
    logic   r_vld1, r_vld2, r_vld3;
    logic   r_final1;
    t_block r_key1, r_key2;
    t_block r_sub1;
    t_block r_mix2;
    t_block r_res3;

    logic   w_en1, w_en2, w_en3;

    // stage advance: a stage loads when empty or when it drains this cycle
    assign w_en3   = !r_vld3 || i_ready;
    assign w_en2   = !r_vld2 || w_en3;
    assign w_en1   = !r_vld1 || w_en2;
    assign o_ready = w_en1;

    assign w_state_in = {i_state_high, i_state_low};

    // subbytes with shiftrows folded into the byte selection
    always_comb begin
        for (int c = 0; c < NumCols; c++) begin
            for (int r = 0; r < NumCols; r++) begin
                n_sub[8*(NumBytes-1-(c*4+r)) +: 8] =
                    SBOX[w_state_in[8*(NumBytes-1-(((c+r)%4)*4+r)) +: 8]];
            end
        end
    end

    // mixcolumns, one unit per column
    for (genvar g = 0; g < NumCols; g++) begin : g_mix
        aer_mix_column u_mix (
            .i_col(r_sub1[32*(NumCols-1-g) +: 32]),
            .o_col(w_mixed[32*(NumCols-1-g) +: 32])
        );
    end

    // final round bypasses the column mix
    assign n_mix = r_final1 ? r_sub1 : w_mixed;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_en1) r_vld1 <= i_valid;
            if (w_en2) r_vld2 <= r_vld1;
            if (w_en3) r_vld3 <= r_vld2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sub1   <= n_sub;
            r_key1   <= {i_key_high, i_key_low};
            r_final1 <= i_final_round;
        end
        if (w_en2) begin
            r_mix2 <= n_mix;
            r_key2 <= r_key1;
        end
        if (w_en3) begin
            r_res3 <= r_mix2 ^ r_key2;
        end
    end

    assign o_valid       = r_vld3;
    assign o_result_high = r_res3[127:64];
    assign o_result_low  = r_res3[63:0];

    // input is refused only when every stage is full
    `AER_ASSERT_IMP(a_full_when_blocked, i_clk, i_rst_n, !o_ready, r_vld1 && r_vld2 && r_vld3)
    // an input transfer always lands in the first stage
    `AER_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld1)
    // a full second stage moves on when the output stage is free
    `AER_ASSERT_NXT(a_mid_advances, i_clk, i_rst_n, r_vld2 && !r_vld3, r_vld3)
    // an output stall with the middle full keeps the middle full
    `AER_ASSERT_NXT(a_mid_holds, i_clk, i_rst_n, r_vld2 && r_vld3 && !i_ready, r_vld2)

endmodule
